### hdl/mttp_pkg.sv
// Shared types and constants for the minimum-time trapezoid profile unit.
// Used by the divider, the top level and the checker; depends on nothing.
`timescale 1ns / 1ps

package mttp_pkg;

    // Default number of fraction bits in the fixed-point values.
    localparam int FRAC_BITS_DEF = 16;

    // Width of the unsigned time and velocity results.
    localparam int QW = 31;

    // Reset values of the velocity limit registers.
    localparam logic [31:0] MIN_VELOCITY_RST = 32'd0;
    localparam logic [31:0] MAX_VELOCITY_RST = 32'd65536;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_BAD_LIMITS    = 3'd1,
        ST_OUT_OF_LIMITS = 3'd2,
        ST_NONPOSITIVE   = 3'd3,
        ST_TOO_SHORT     = 3'd4
    } t_status;

    // Profile shapes.
    typedef enum logic [1:0] {
        KIND_NONE      = 2'd0,
        KIND_TRIANGLE  = 2'd1,
        KIND_TRAPEZOID = 2'd2
    } t_kind;

    // Configuration register indexes.
    typedef enum logic {
        REG_MIN_VELOCITY = 1'b0,
        REG_MAX_VELOCITY = 1'b1
    } t_reg_index;

    // Add two times and clamp at the largest representable value.
    function automatic logic [QW-1:0] sat_add(input logic [QW-1:0] a, input logic [QW-1:0] b);
        logic [QW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[QW] ? {QW{1'b1}} : s[QW-1:0];
    endfunction

endpackage

### hdl/mttp_div.sv
// Pipelined saturating fixed-point divider, one quotient bit per stage.
// Depends on mttp_pkg for the result width.
`timescale 1ns / 1ps

module mttp_div #(
    parameter int NUM_W     = 63,
    parameter int DEN_W     = 63,
    parameter int FRAC_BITS = mttp_pkg::FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [NUM_W-1:0]       i_num,
    input  logic [DEN_W-1:0]       i_den,
    output logic [mttp_pkg::QW-1:0] o_quo
);

    localparam int QW = mttp_pkg::QW;
    localparam int SH = QW - FRAC_BITS;
    localparam int WW = ((NUM_W > DEN_W) ? NUM_W : DEN_W) + 1;

    typedef struct packed {
        logic             sat;
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [NUM_W-1:0] num;
        logic [QW-1:0]    quo;
    } t_div_stage;

    t_div_stage r_stg [QW+1];
    t_div_stage n_stg [QW+1];

    logic [WW-1:0] w_top;
    logic          w_sat;

    // The quotient overflows exactly when the numerator's high part reaches the divisor.
    assign w_top = WW'(i_num) >> SH;
    assign w_sat = w_top >= WW'(i_den);

    always_comb begin
        n_stg[0].sat = w_sat;
        n_stg[0].rem = w_sat ? '0 : w_top[DEN_W-1:0];
        n_stg[0].den = i_den;
        n_stg[0].num = i_num;
        n_stg[0].quo = '0;
    end

    // One restoring step per stage, most significant quotient bit first.
    for (genvar k = 0; k < QW; k++) begin : g_step
        localparam int BI = QW - 1 - k;
        logic             w_xbit;
        logic [DEN_W:0]   w_trial;
        logic [DEN_W:0]   w_diff;
        logic             w_take;

        if (BI >= FRAC_BITS) begin : g_num
            assign w_xbit = r_stg[k].num[BI-FRAC_BITS];
        end else begin : g_zero
            assign w_xbit = 1'b0;
        end

        assign w_trial = {r_stg[k].rem, w_xbit};
        assign w_diff  = w_trial - {1'b0, r_stg[k].den};
        assign w_take  = w_trial >= {1'b0, r_stg[k].den};

        always_comb begin
            n_stg[k+1]         = r_stg[k];
            n_stg[k+1].rem     = w_take ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            n_stg[k+1].quo[BI] = w_take;
        end
    end

    // Stage registers advance together.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= QW; k++) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    assign o_quo = r_stg[QW].sat ? {QW{1'b1}} : r_stg[QW].quo;

endmodule

### hdl/min_time_trapezoid_profile_unit.sv
// Top level of the minimum-time trapezoid profile unit.
// Depends on mttp_pkg and mttp_div.
`timescale 1ns / 1ps

// Plans the fastest accelerate, cruise, decelerate move for each request on the slave stream
// and returns one result transaction per request, in order. The unit takes a new request in
// every cycle in which the result register is free or being read; each request passes through
// three stages of products and compares, a 32-stage square-root pipeline (running beside the
// 32-stage cruise-time divider), one stage to form the ramp numerators, the 32-stage ramp
// dividers, and two stages of saturating sums. The square root and the dividers produce one
// result bit per stage, which sets the depth. A back-pressured output freezes the whole
// pipeline, so nothing is dropped or repeated. The user must write the velocity limits on the
// configuration port only while no request is in flight; the unit itself does not enforce this.
module min_time_trapezoid_profile_unit #(
    parameter int FRAC_BITS = mttp_pkg::FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Request stream.
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // distance[31:0], start_velocity[63:32], end_velocity[95:64], acceleration[127:96]
    input  logic [127:0] i_s_axis_tdata,
    // Result stream.
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // accel_end_time[30:0], cruise_end_time[61:31], total_time[92:62],
    // plateau_velocity[123:93], zero[127:124]
    output logic [127:0] o_m_axis_tdata,
    // status[2:0], profile_kind[4:3]
    output logic [4:0]   o_m_axis_tuser,
    // Configuration write port.
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_data
);

    localparam int QW       = mttp_pkg::QW;
    localparam int SQ_STEPS = 32;
    localparam int DIV_LAT  = QW + 1;

    typedef struct packed {
        mttp_pkg::t_status status;
        logic [30:0]       p;
        logic [30:0]       q;
        logic [30:0]       a;
        logic [30:0]       v;
        logic [61:0]       da;
        logic [61:0]       p2;
        logic [61:0]       q2;
        logic [61:0]       v2;
        logic [61:0]       av;
    } t_s1;

    typedef struct packed {
        mttp_pkg::t_status status;
        logic [30:0]       p;
        logic [30:0]       q;
        logic [30:0]       a;
        logic [30:0]       v;
        logic [62:0]       twoda;
        logic [61:0]       diff;
        logic [62:0]       rhs;
        logic [62:0]       sx;
        logic [62:0]       den12;
    } t_s2;

    typedef struct packed {
        mttp_pkg::t_status status;
        mttp_pkg::t_kind   kind;
        logic [30:0]       p;
        logic [30:0]       q;
        logic [30:0]       a;
        logic [30:0]       v;
        logic [62:0]       sx;
        logic [62:0]       num12;
        logic [62:0]       den12;
    } t_s3;

    typedef struct packed {
        mttp_pkg::t_status status;
        mttp_pkg::t_kind   kind;
        logic [30:0]       p;
        logic [30:0]       q;
        logic [30:0]       a;
        logic [30:0]       v;
        logic [63:0]       x;
        logic [35:0]       rem;
        logic [31:0]       root;
    } t_sq;

    typedef struct packed {
        mttp_pkg::t_status status;
        mttp_pkg::t_kind   kind;
        logic [30:0]       vp;
        logic [30:0]       t12;
        logic [30:0]       n1;
        logic [30:0]       n3;
        logic [30:0]       a;
    } t_s4;

    typedef struct packed {
        mttp_pkg::t_status status;
        mttp_pkg::t_kind   kind;
        logic [30:0]       vp;
        logic [30:0]       t12;
    } t_side;

    typedef struct packed {
        mttp_pkg::t_status status;
        mttp_pkg::t_kind   kind;
        logic [30:0]       vp;
        logic [30:0]       t1;
        logic [30:0]       t2;
        logic [30:0]       t3q;
    } t_s5;

    // One step of the digit-by-digit square root: two radicand bits in, one root bit out.
    function automatic t_sq sq_step(input t_sq s, input logic [1:0] b);
        t_sq        o;
        logic [35:0] trial;
        logic [35:0] test;
        logic        take;
        o     = s;
        trial = {s.rem[33:0], b};
        test  = {2'b00, s.root, 2'b01};
        take  = trial >= test;
        o.rem  = take ? (trial - test) : trial;
        o.root = {s.root[30:0], take};
        return o;
    endfunction

    logic [31:0] r_min_vel;
    logic [31:0] r_max_vel;

    logic w_en;

    logic                r1_valid;
    t_s1                 r1;
    t_s1                 n1;
    logic                r2_valid;
    t_s2                 r2;
    t_s2                 n2;
    logic                r3_valid;
    t_s3                 r3;
    t_s3                 n3;
    logic [SQ_STEPS-1:0] r_sq_valid;
    t_sq                 r_sq [SQ_STEPS];
    t_sq                 n_sq [SQ_STEPS];
    t_sq                 w_sq_in;
    logic [QW-1:0]       w_q12;
    logic                r4_valid;
    t_s4                 r4;
    t_s4                 n4;
    logic [DIV_LAT-1:0]  r_dl_valid;
    t_side               r_dl [DIV_LAT];
    logic [QW-1:0]       w_q1;
    logic [QW-1:0]       w_q3;
    logic                r5_valid;
    t_s5                 r5;
    t_s5                 n5;
    logic                r_out_valid;
    logic [127:0]        r_out_tdata;
    logic [4:0]          r_out_tuser;

    logic signed [31:0] w_d;
    logic signed [31:0] w_v0;
    logic signed [31:0] w_vf;
    logic signed [31:0] w_a;
    logic signed [31:0] w_vmin;
    logic signed [31:0] w_vmax;

    // Velocity limit registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_vel <= mttp_pkg::MIN_VELOCITY_RST;
            r_max_vel <= mttp_pkg::MAX_VELOCITY_RST;
        end else if (i_cfg_we) begin
            unique case (mttp_pkg::t_reg_index'(i_cfg_addr))
                mttp_pkg::REG_MIN_VELOCITY: r_min_vel <= i_cfg_data;
                mttp_pkg::REG_MAX_VELOCITY: r_max_vel <= i_cfg_data;
                default:                    r_min_vel <= r_min_vel;
            endcase
        end
    end

    // The whole pipeline moves whenever the result register can take a new value.
    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    assign w_d    = $signed(i_s_axis_tdata[31:0]);
    assign w_v0   = $signed(i_s_axis_tdata[63:32]);
    assign w_vf   = $signed(i_s_axis_tdata[95:64]);
    assign w_a    = $signed(i_s_axis_tdata[127:96]);
    assign w_vmin = $signed(r_min_vel);
    assign w_vmax = $signed(r_max_vel);

    // Stage 1: ordered request checks and the products.
    always_comb begin
        if (w_vmin < 0 || w_vmax <= w_vmin) begin
            n1.status = mttp_pkg::ST_BAD_LIMITS;
        end else if (w_v0 < w_vmin || w_v0 > w_vmax || w_vf < w_vmin || w_vf > w_vmax) begin
            n1.status = mttp_pkg::ST_OUT_OF_LIMITS;
        end else if (w_d <= 0 || w_a <= 0) begin
            n1.status = mttp_pkg::ST_NONPOSITIVE;
        end else begin
            n1.status = mttp_pkg::ST_OK;
        end
        n1.p  = w_v0[30:0];
        n1.q  = w_vf[30:0];
        n1.a  = w_a[30:0];
        n1.v  = w_vmax[30:0];
        n1.da = 62'(w_d[30:0]) * 62'(w_a[30:0]);
        n1.p2 = 62'(w_v0[30:0]) * 62'(w_v0[30:0]);
        n1.q2 = 62'(w_vf[30:0]) * 62'(w_vf[30:0]);
        n1.v2 = 62'(w_vmax[30:0]) * 62'(w_vmax[30:0]);
        n1.av = 62'(w_a[30:0]) * 62'(w_vmax[30:0]);
    end

    // Stage 2: energy terms of the feasibility and peak tests.
    always_comb begin
        logic [63:0] rhs;
        logic [62:0] pq;
        rhs       = {1'b0, r1.v2, 1'b0} - {2'b00, r1.p2} - {2'b00, r1.q2};
        pq        = {1'b0, r1.p2} + {1'b0, r1.q2};
        n2.status = r1.status;
        n2.p      = r1.p;
        n2.q      = r1.q;
        n2.a      = r1.a;
        n2.v      = r1.v;
        n2.twoda  = {r1.da, 1'b0};
        n2.diff   = (r1.p2 > r1.q2) ? (r1.p2 - r1.q2) : (r1.q2 - r1.p2);
        n2.rhs    = rhs[62:0];
        n2.sx     = {1'b0, r1.da} + {1'b0, pq[62:1]};
        n2.den12  = {r1.av, 1'b0};
    end

    // Stage 3: too-short check and choice of profile shape.
    always_comb begin
        if (r2.status == mttp_pkg::ST_OK && r2.twoda < {1'b0, r2.diff}) begin
            n3.status = mttp_pkg::ST_TOO_SHORT;
        end else begin
            n3.status = r2.status;
        end
        if (n3.status != mttp_pkg::ST_OK) begin
            n3.kind = mttp_pkg::KIND_NONE;
        end else if (r2.twoda < r2.rhs) begin
            n3.kind = mttp_pkg::KIND_TRIANGLE;
        end else begin
            n3.kind = mttp_pkg::KIND_TRAPEZOID;
        end
        n3.p     = r2.p;
        n3.q     = r2.q;
        n3.a     = r2.a;
        n3.v     = r2.v;
        n3.sx    = r2.sx;
        n3.num12 = r2.twoda - r2.rhs;
        n3.den12 = r2.den12;
    end

    // Square-root pipeline for the triangular peak velocity.
    always_comb begin
        w_sq_in.status = r3.status;
        w_sq_in.kind   = r3.kind;
        w_sq_in.p      = r3.p;
        w_sq_in.q      = r3.q;
        w_sq_in.a      = r3.a;
        w_sq_in.v      = r3.v;
        w_sq_in.x      = {1'b0, r3.sx};
        w_sq_in.rem    = '0;
        w_sq_in.root   = '0;
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        localparam int J = SQ_STEPS - 1 - k;
        if (k == 0) begin : g_first
            assign n_sq[k] = sq_step(w_sq_in, w_sq_in.x[2*J+1 -: 2]);
        end else begin : g_next
            assign n_sq[k] = sq_step(r_sq[k-1], r_sq[k-1].x[2*J+1 -: 2]);
        end
    end

    // Cruise time runs beside the square root and comes out in the same cycle.
    mttp_div #(
        .NUM_W     (63),
        .DEN_W     (63),
        .FRAC_BITS (FRAC_BITS)
    ) u_div_cruise (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r3.num12),
        .i_den (r3.den12),
        .o_quo (w_q12)
    );

    // Stage 4: plateau velocity and the ramp numerators.
    always_comb begin
        t_sq last;
        last      = r_sq[SQ_STEPS-1];
        n4.status = last.status;
        n4.kind   = last.kind;
        n4.vp     = (last.kind == mttp_pkg::KIND_TRIANGLE) ? last.root[30:0] : last.v;
        n4.t12    = (last.kind == mttp_pkg::KIND_TRAPEZOID) ? w_q12 : '0;
        n4.n1     = n4.vp - last.p;
        n4.n3     = n4.vp - last.q;
        n4.a      = last.a;
    end

    // Ramp-up and ramp-down times.
    mttp_div #(
        .NUM_W     (31),
        .DEN_W     (31),
        .FRAC_BITS (FRAC_BITS)
    ) u_div_up (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r4.n1),
        .i_den (r4.a),
        .o_quo (w_q1)
    );

    mttp_div #(
        .NUM_W     (31),
        .DEN_W     (31),
        .FRAC_BITS (FRAC_BITS)
    ) u_div_down (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r4.n3),
        .i_den (r4.a),
        .o_quo (w_q3)
    );

    // Stage 5: end of the cruise phase.
    always_comb begin
        n5.status = r_dl[DIV_LAT-1].status;
        n5.kind   = r_dl[DIV_LAT-1].kind;
        n5.vp     = r_dl[DIV_LAT-1].vp;
        n5.t1     = w_q1;
        n5.t2     = mttp_pkg::sat_add(w_q1, r_dl[DIV_LAT-1].t12);
        n5.t3q    = w_q3;
    end

    // Payload registers of all stages.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1 <= n1;
            r2 <= n2;
            r3 <= n3;
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_sq[k] <= n_sq[k];
            end
            r4 <= n4;
            r_dl[0] <= '{status: r4.status, kind: r4.kind, vp: r4.vp, t12: r4.t12};
            for (int k = 1; k < DIV_LAT; k++) begin
                r_dl[k] <= r_dl[k-1];
            end
            r5 <= n5;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_sq_valid  <= '0;
            r4_valid    <= 1'b0;
            r_dl_valid  <= '0;
            r5_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid    <= i_s_axis_tvalid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r_sq_valid  <= {r_sq_valid[SQ_STEPS-2:0], r3_valid};
            r4_valid    <= r_sq_valid[SQ_STEPS-1];
            r_dl_valid  <= {r_dl_valid[DIV_LAT-2:0], r4_valid};
            r5_valid    <= r_dl_valid[DIV_LAT-1];
            r_out_valid <= r5_valid;
        end
    end

    // Output register: total time, and all-zero fields for a rejected request.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r5.status != mttp_pkg::ST_OK) begin
                r_out_tdata <= '0;
                r_out_tuser <= {mttp_pkg::KIND_NONE, r5.status};
            end else begin
                r_out_tdata <= {4'b0000, r5.vp, mttp_pkg::sat_add(r5.t2, r5.t3q), r5.t2, r5.t1};
                r_out_tuser <= {r5.kind, r5.status};
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_tdata;
    assign o_m_axis_tuser  = r_out_tuser;

endmodule

### hdl/mttp_checker.sv
// Port-level checks for the minimum-time trapezoid profile unit, bound to the top level.
// Depends on mttp_pkg and min_time_trapezoid_profile_unit.
`timescale 1ns / 1ps

module mttp_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_s_axis_tready,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [127:0] o_m_axis_tdata,
    input logic [4:0]   o_m_axis_tuser
);

    // A stalled result transaction holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // Requests are taken whenever the result register is free or draining.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("request ready does not follow result stall");

    // A rejected request carries no profile.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[2:0] != mttp_pkg::ST_OK |->
            o_m_axis_tuser[4:3] == mttp_pkg::KIND_NONE && o_m_axis_tdata == '0)
        else $error("rejected request has profile data");

    // A planned move has a shape and its switch times never go backward.
    a_times_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[2:0] == mttp_pkg::ST_OK |->
            o_m_axis_tuser[4:3] != mttp_pkg::KIND_NONE &&
            o_m_axis_tdata[30:0] <= o_m_axis_tdata[61:31] &&
            o_m_axis_tdata[61:31] <= o_m_axis_tdata[92:62])
        else $error("switch times out of order");

endmodule

bind min_time_trapezoid_profile_unit mttp_checker u_mttp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

### verif/min_time_trapezoid_profile_unit_test.sv
// Self-checking testbench for the minimum-time trapezoid profile unit.
// Drives move requests and velocity limits, predicts every result and compares.
// Depends on mttp_pkg and the unit's RTL.
`timescale 1ns / 1ps

module min_time_trapezoid_profile_unit_test;

    localparam longint unsigned SAT = 64'h7FFF_FFFF;
    localparam int FRAC = 16;
    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 1800;

    typedef struct packed {
        logic signed [31:0] distance;
        logic signed [31:0] v0;
        logic signed [31:0] vf;
        logic signed [31:0] accel;
    } t_move;

    typedef struct packed {
        mttp_pkg::t_status status;
        mttp_pkg::t_kind   kind;
        logic [30:0]       t_accel;
        logic [30:0]       t_cruise;
        logic [30:0]       t_total;
        logic [30:0]       v_plateau;
    } t_plan;

    // Directed row: limits, request, and a status typed in where obvious.
    typedef struct {
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        t_move              mv;
        bit                 fixed;
        mttp_pkg::t_status  st;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [127:0] i_s_axis_tdata = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [127:0] o_m_axis_tdata;
    logic [4:0]   o_m_axis_tuser;
    logic         i_cfg_we = 1'b0;
    logic [0:0]   i_cfg_addr = '0;
    logic [31:0]  i_cfg_data = '0;

    // Limits as the unit holds them.
    logic signed [31:0] lim_lo = mttp_pkg::MIN_VELOCITY_RST;
    logic signed [31:0] lim_hi = mttp_pkg::MAX_VELOCITY_RST;

    t_plan pending_plans[$];
    int    errors = 0;
    int    moves_sent = 0;
    int    plans_seen = 0;
    int    idle_cycles = 0;
    int    seen_status[8];
    int    seen_kind[4];
    bit    no_gaps = 1'b0;

    min_time_trapezoid_profile_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Exact floor(num * 2^FRAC / den), clamped to 31 bits.
    function automatic longint unsigned ratio_q(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned whole, rem, acc;
        whole = num / den;
        rem = num % den;
        if (whole > (SAT >> FRAC)) return SAT;
        acc = whole << FRAC;
        for (int i = FRAC - 1; i >= 0; i--) begin
            rem = rem << 1;
            if (rem >= den) begin
                rem = rem - den;
                acc[i] = 1'b1;
            end
        end
        return (acc > SAT) ? SAT : acc;
    endfunction

    function automatic longint unsigned clamp_sum(input longint unsigned a,
                                                  input longint unsigned b);
        return (a + b > SAT) ? SAT : a + b;
    endfunction

    // Floor square root, one result bit per step from the top.
    function automatic longint unsigned floor_root(input longint unsigned x);
        longint unsigned r, trial;
        r = 0;
        for (int i = 31; i >= 0; i--) begin
            trial = r | (64'd1 << i);
            if (trial * trial <= x) r = trial;
        end
        return r;
    endfunction

    // Minimum-time profile for one move under the given limits.
    function automatic t_plan plan_move(input t_move m, input logic signed [31:0] lo,
                                        input logic signed [31:0] hi);
        t_plan res;
        longint unsigned ud, ua, p, q, v, p2, q2, twoda, diff, rhs, t12, vp, t1, t2, t3;
        res = '0;
        res.status = mttp_pkg::ST_OK;
        res.kind = mttp_pkg::KIND_NONE;
        if (lo < 0 || hi <= lo) begin
            res.status = mttp_pkg::ST_BAD_LIMITS;
        end else if (m.v0 < lo || m.v0 > hi || m.vf < lo || m.vf > hi) begin
            res.status = mttp_pkg::ST_OUT_OF_LIMITS;
        end else if (m.distance <= 0 || m.accel <= 0) begin
            res.status = mttp_pkg::ST_NONPOSITIVE;
        end else begin
            ud = {32'd0, m.distance};
            ua = {32'd0, m.accel};
            p = {32'd0, m.v0};
            q = {32'd0, m.vf};
            v = {32'd0, hi};
            p2 = p * p;
            q2 = q * q;
            twoda = 2 * ud * ua;
            diff = (p2 > q2) ? p2 - q2 : q2 - p2;
            if (twoda < diff) begin
                res.status = mttp_pkg::ST_TOO_SHORT;
            end else begin
                rhs = 2 * v * v - p2 - q2;
                t12 = 0;
                if (twoda < rhs) begin
                    res.kind = mttp_pkg::KIND_TRIANGLE;
                    vp = floor_root((twoda + p2 + q2) >> 1);
                end else begin
                    res.kind = mttp_pkg::KIND_TRAPEZOID;
                    vp = v;
                    t12 = ratio_q(twoda - rhs, 2 * ua * v);
                end
                t1 = ratio_q(vp - p, ua);
                t2 = clamp_sum(t1, t12);
                t3 = clamp_sum(t2, ratio_q(vp - q, ua));
                res.t_accel = t1[30:0];
                res.t_cruise = t2[30:0];
                res.t_total = t3[30:0];
                res.v_plateau = vp[30:0];
            end
        end
        return res;
    endfunction

    task automatic report(input string what, input longint unsigned want,
                          input longint unsigned got);
        $display("[%0t] mismatch in %s: expected %0h, got %0h", $realtime, what, want, got);
        errors++;
    endtask

    // Both limit registers are written back to back while the unit is idle.
    task automatic write_limits(input logic signed [31:0] lo, input logic signed [31:0] hi);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= mttp_pkg::REG_MIN_VELOCITY;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_addr <= mttp_pkg::REG_MAX_VELOCITY;
        i_cfg_data <= hi;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        lim_lo = lo;
        lim_hi = hi;
    endtask

    task automatic wait_drained();
        while (pending_plans.size() != 0) @(posedge i_clk);
    endtask

    // One request transaction with a random gap in front; returns the prediction.
    task automatic send_move(input t_move m, output t_plan pred);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {m.accel, m.vf, m.v0, m.distance};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pred = plan_move(m, lim_lo, lim_hi);
        pending_plans.push_back(pred);
        moves_sent++;
    endtask

    function automatic logic [31:0] scaled_positive();
        logic [31:0] x;
        x = {1'b0, 31'($urandom)} >> $urandom_range(0, 31);
        return (x == 0) ? 32'd1 : x;
    endfunction

    function automatic logic signed [31:0] within_limits();
        longint span;
        span = longint'(lim_hi) - longint'(lim_lo) + 1;
        if (span <= 0) return lim_lo;
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? lim_hi : lim_lo;
        return 32'(longint'(lim_lo) + ({$urandom, $urandom} % span));
    endfunction

    // Stimulus: directed table, then random phases under varied limits.
    initial begin
        t_row rows[$];
        t_move m;
        t_plan pred;
        logic signed [31:0] lo, hi;
        int phase_len;

        rows = '{
            '{0, 65536, '{65536, 0, 0, 65536}, 0, mttp_pkg::ST_OK},
            '{0, 65536, '{100, 0, 0, 65536}, 0, mttp_pkg::ST_OK},
            '{0, 65536, '{65536, 65537, 0, 65536}, 1, mttp_pkg::ST_OUT_OF_LIMITS},
            '{0, 65536, '{65536, 0, -1, 65536}, 1, mttp_pkg::ST_OUT_OF_LIMITS},
            '{0, 65536, '{0, 0, 0, 65536}, 1, mttp_pkg::ST_NONPOSITIVE},
            '{0, 65536, '{65536, 0, 0, 0}, 1, mttp_pkg::ST_NONPOSITIVE},
            '{0, 65536, '{32'h8000_0000, 0, 0, 65536}, 1, mttp_pkg::ST_NONPOSITIVE},
            '{0, 65536, '{65536, 0, 0, -1}, 1, mttp_pkg::ST_NONPOSITIVE},
            '{0, 65536, '{1, 65536, 0, 1}, 1, mttp_pkg::ST_TOO_SHORT},
            '{0, 65536, '{300000, 65536, 65536, 65536}, 0, mttp_pkg::ST_OK},
            '{0, 32'h7FFF_FFFF, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                  32'h7FFF_FFFF}, 0, mttp_pkg::ST_OK},
            '{0, 32'h7FFF_FFFF, '{1, 0, 0, 1}, 0, mttp_pkg::ST_OK},
            '{0, 32'h7FFF_FFFF, '{1, 0, 32'h7FFF_FFFF, 1}, 1, mttp_pkg::ST_TOO_SHORT},
            '{0, 32'h7FFF_FFFF, '{32'h7FFF_FFFF, 0, 0, 1}, 0, mttp_pkg::ST_OK},
            '{0, 1, '{1, 1, 0, 1}, 0, mttp_pkg::ST_OK},
            '{0, 1, '{32'h7FFF_FFFF, 0, 1, 32'h7FFF_FFFF}, 0, mttp_pkg::ST_OK},
            '{-1, 65536, '{65536, 0, 0, 65536}, 1, mttp_pkg::ST_BAD_LIMITS},
            '{32'h8000_0000, 32'h7FFF_FFFF, '{65536, 0, 0, 65536}, 1,
              mttp_pkg::ST_BAD_LIMITS},
            '{5, 5, '{65536, 5, 5, 65536}, 1, mttp_pkg::ST_BAD_LIMITS},
            '{10, 5, '{65536, 7, 7, 65536}, 1, mttp_pkg::ST_BAD_LIMITS}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].lo !== lim_lo || rows[i].hi !== lim_hi) begin
                i_s_axis_tvalid <= 1'b0;
                wait_drained();
                write_limits(rows[i].lo, rows[i].hi);
            end
            send_move(rows[i].mv, pred);
            if (rows[i].fixed && pred.status != rows[i].st)
                report("directed status", rows[i].st, pred.status);
        end

        // Random phases; each one starts from an idle unit with new limits.
        while (moves_sent < RANDOM_ITEMS + rows.size()) begin
            i_s_axis_tvalid <= 1'b0;
            wait_drained();
            case ($urandom_range(0, 6))
                0: begin lo = 0; hi = 65536; end
                1: begin lo = 0; hi = 32'h7FFF_FFFF; end
                2: begin lo = 0; hi = 1; end
                3: begin lo = $urandom_range(0, 1 << 20); hi = lo + scaled_positive(); end
                4: begin lo = $urandom; hi = $urandom; end
                5: begin lo = $urandom_range(0, 32'h3FFF_FFFF); hi = 32'h7FFF_FFFF; end
                default: begin lo = 0; hi = scaled_positive(); end
            endcase
            if (hi < lo && $urandom_range(0, 3) != 0) hi = 32'h7FFF_FFFF;
            write_limits(lo, hi);
            no_gaps = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(60, 200);
            repeat (phase_len) begin
                if ($urandom_range(0, 99) < 85) begin
                    m.distance = scaled_positive();
                    m.accel = scaled_positive();
                    m.v0 = within_limits();
                    m.vf = within_limits();
                end else begin
                    m = {$urandom, $urandom, $urandom, $urandom};
                end
                send_move(m, pred);
            end
        end
        i_s_axis_tvalid <= 1'b0;

        wait_drained();
        repeat (100) @(posedge i_clk);
        $display("Planned %0d moves: ok %0d, bad limits %0d, out of limits %0d,",
                 plans_seen, seen_status[mttp_pkg::ST_OK],
                 seen_status[mttp_pkg::ST_BAD_LIMITS],
                 seen_status[mttp_pkg::ST_OUT_OF_LIMITS]);
        $display("nonpositive %0d, too short %0d, triangles %0d, trapezoids %0d.",
                 seen_status[mttp_pkg::ST_NONPOSITIVE], seen_status[mttp_pkg::ST_TOO_SHORT],
                 seen_kind[mttp_pkg::KIND_TRIANGLE], seen_kind[mttp_pkg::KIND_TRAPEZOID]);
        if (errors == 0) begin
            $display("min_time_trapezoid_profile_unit_test: done, clean");
        end else begin
            $display("min_time_trapezoid_profile_unit_test: done, errors");
        end
        $finish;
    end

    // Result side: random stalls, then compare each transaction with the oldest plan.
    initial begin
        t_plan want;
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            plans_seen++;
            if (pending_plans.size() == 0) begin
                report("unexpected result", 0, o_m_axis_tdata[63:0]);
            end else begin
                want = pending_plans.pop_front();
                seen_status[want.status]++;
                seen_kind[want.kind]++;
                if (o_m_axis_tuser[2:0] !== want.status)
                    report("status", want.status, o_m_axis_tuser[2:0]);
                if (o_m_axis_tuser[4:3] !== want.kind)
                    report("profile_kind", want.kind, o_m_axis_tuser[4:3]);
                if (o_m_axis_tdata[30:0] !== want.t_accel)
                    report("accel_end_time", want.t_accel, o_m_axis_tdata[30:0]);
                if (o_m_axis_tdata[61:31] !== want.t_cruise)
                    report("cruise_end_time", want.t_cruise, o_m_axis_tdata[61:31]);
                if (o_m_axis_tdata[92:62] !== want.t_total)
                    report("total_time", want.t_total, o_m_axis_tdata[92:62]);
                if (o_m_axis_tdata[123:93] !== want.v_plateau)
                    report("plateau_velocity", want.v_plateau, o_m_axis_tdata[123:93]);
            end
        end
    end

    // Watchdog on cycles in which no transaction happens on either stream.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding.", pending_plans.size());
            $display("min_time_trapezoid_profile_unit_test: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
